// ===== rtl/core/dbfd_pkg.sv =====
package dbfd_pkg;

  localparam int MAP_BITS  = 1024;
  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_AW    = $clog2(WORD_BITS);
  localparam int SIZE_W    = $clog2(MAP_BITS + 1);
  localparam int FIELD_W   = 11;
  localparam int INDEX_W   = 10;

  localparam logic [FIELD_W-1:0] ACTIVE_BITS_RESET = FIELD_W'(1024);

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  typedef struct packed {
    logic               operation;
    logic               map_select;
    logic [INDEX_W-1:0] bit_index;
    logic               bit_value;
  } in_word_t;

  typedef struct packed {
    logic               changed;
    logic               index_error;
    logic [FIELD_W-1:0] count_first;
    logic [FIELD_W-1:0] count_second;
    logic [FIELD_W-1:0] diff_position;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic apply_set;
    logic scan_step;
    logic publish;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_stop;
  } dp_status_t;

endpackage

// ===== rtl/core/dbfd_ctrl.sv =====
module dbfd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_op,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output dbfd_pkg::dp_cmd_t    cmd,
  input  dbfd_pkg::dp_status_t status
);
  import dbfd_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SET_BIT,
    SCAN,
    DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != IDLE);

  always_comb begin
    cmd           = '0;
    cmd.capture   = (state == IDLE) && in_valid;
    cmd.apply_set = (state == SET_BIT);
    cmd.scan_step = (state == SCAN);
    cmd.publish   = (state == DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      priority if ((state == DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= (in_op == OP_FIND) ? SCAN : SET_BIT;
          end
        end
        SET_BIT: begin
          state <= DONE;
        end
        SCAN: begin
          if (status.scan_stop) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/dbfd_datapath.sv =====
module dbfd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dbfd_pkg::FIELD_W-1:0]  cfg_data,
  input  dbfd_pkg::in_word_t            in_data,
  output dbfd_pkg::out_word_t           out_data,
  input  dbfd_pkg::dp_cmd_t             cmd,
  output dbfd_pkg::dp_status_t          status
);
  import dbfd_pkg::*;

  logic [WORD_BITS-1:0] first_map  [NUM_WORDS];
  logic [WORD_BITS-1:0] second_map [NUM_WORDS];
  logic [SIZE_W-1:0]    first_count;
  logic [SIZE_W-1:0]    second_count;
  logic [FIELD_W-1:0]   active_bits;

  in_word_t             item;
  logic [WORD_AW-1:0]   word_ptr;
  logic                 res_changed;
  logic                 res_err;
  logic [FIELD_W-1:0]   res_diff;

  logic [SIZE_W-1:0]    eff_size;
  logic [WORD_AW-1:0]   set_word;
  logic [BIT_AW-1:0]    set_bit;
  logic                 idx_err;
  logic [WORD_AW-1:0]   rd_addr;
  logic [WORD_BITS-1:0] first_rd;
  logic [WORD_BITS-1:0] second_rd;
  logic                 old_bit;
  logic                 flip;

  logic [SIZE_W-1:0]    base;
  logic [SIZE_W-1:0]    remain;
  logic                 past_end;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] diff_bits;
  logic [WORD_BITS-1:0] lowest;
  logic [BIT_AW-1:0]    low_pos;
  logic                 hit;
  logic                 last_word;

  assign eff_size = (32'(active_bits) > 32'(MAP_BITS)) ? SIZE_W'(MAP_BITS)
                                                        : SIZE_W'(active_bits);

  assign set_word = WORD_AW'(32'(item.bit_index) / WORD_BITS);
  assign set_bit  = BIT_AW'(32'(item.bit_index) % WORD_BITS);
  assign idx_err  = 32'(item.bit_index) >= 32'(eff_size);

  assign rd_addr   = cmd.scan_step ? word_ptr : set_word;
  assign first_rd  = first_map[rd_addr];
  assign second_rd = second_map[rd_addr];

  assign old_bit = item.map_select ? second_rd[set_bit] : first_rd[set_bit];
  assign flip    = !idx_err && (old_bit != item.bit_value);

  assign base      = SIZE_W'(32'(word_ptr) * WORD_BITS);
  assign past_end  = base >= eff_size;
  assign remain    = eff_size - base;
  assign mask      = (32'(remain) >= WORD_BITS) ? {WORD_BITS{1'b1}}
                                                : ~({WORD_BITS{1'b1}} << remain[BIT_AW-1:0]);
  assign diff_bits = (first_rd ^ second_rd) & mask;
  assign lowest    = diff_bits & (~diff_bits + WORD_BITS'(1));
  assign hit       = !past_end && (diff_bits != '0);
  assign last_word = (32'(word_ptr) == NUM_WORDS - 1);

  always_comb begin
    low_pos = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        low_pos = low_pos | BIT_AW'(b);
      end
    end
  end

  always_comb begin
    status           = '0;
    status.scan_stop = past_end || hit || last_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bits  <= ACTIVE_BITS_RESET;
      first_count  <= '0;
      second_count <= '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
        first_map[w]  <= '0;
        second_map[w] <= '0;
      end
    end else begin
      if (cfg_write) begin
        active_bits <= cfg_data;
      end
      if (cmd.apply_set && flip) begin
        if (item.map_select) begin
          second_map[set_word][set_bit] <= item.bit_value;
          second_count <= item.bit_value ? second_count + SIZE_W'(1)
                                         : second_count - SIZE_W'(1);
        end else begin
          first_map[set_word][set_bit] <= item.bit_value;
          first_count <= item.bit_value ? first_count + SIZE_W'(1)
                                        : first_count - SIZE_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item        <= in_data;
      word_ptr    <= '0;
      res_changed <= 1'b0;
      res_err     <= 1'b0;
      res_diff    <= '0;
    end
    if (cmd.apply_set) begin
      res_changed <= flip;
      res_err     <= idx_err;
    end
    if (cmd.scan_step) begin
      word_ptr <= word_ptr + WORD_AW'(1);
      if (hit) begin
        res_diff <= FIELD_W'(32'(base) + 32'(low_pos) + 1);
      end
    end
    if (cmd.publish) begin
      out_data.changed       <= res_changed;
      out_data.index_error   <= res_err;
      out_data.count_first   <= FIELD_W'(first_count);
      out_data.count_second  <= FIELD_W'(second_count);
      out_data.diff_position <= res_diff;
    end
  end

endmodule

// ===== rtl/core/dual_bitmap_first_difference_unit.sv =====
// Channel  Direction  Handshake               Word
// in       input      in_valid / in_stall     in_data  (in_word_t)
// out      output     out_valid / out_stall   out_data (out_word_t)
// cfg      input      cfg_valid / cfg_ready   cfg_data (active_bits)
//
// A set goes from acceptance through SET_BIT and DONE to out_valid; a find goes
// through SCAN and then DONE, with the word counter reading one word of each map
// per cycle until a difference, the end of active_bits or the last map word.
// Reset clears both maps and counts and sets active_bits to 1024.
// One item is in flight at a time; a stalled result holds in the output
// register while the unit finishes the next item.
module dual_bitmap_first_difference_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dbfd_pkg::in_word_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dbfd_pkg::out_word_t           out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dbfd_pkg::FIELD_W-1:0]  cfg_data
);
  import dbfd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  dbfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  dbfd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// ===== rtl/core/dbfd_checker.sv =====
module dbfd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input dbfd_pkg::out_word_t out_data
);
  import dbfd_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("unit not idle after reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a word in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result dropped or changed");

endmodule

bind dual_bitmap_first_difference_unit dbfd_checker u_dbfd_checker (.*);

// ===== sim/dual_bitmap_first_difference_unit_tb.sv =====
module dual_bitmap_first_difference_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dbfd_pkg::*;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_SIZE = 1'b1
  } row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [FIELD_W-1:0] span;
    in_word_t           word;
    bit                 typed;
    out_word_t          want;
  } vector_row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FIELD_W-1:0] cfg_data  = '0;

  logic [MAP_BITS-1:0] first_bits   = '0;
  logic [MAP_BITS-1:0] second_bits  = '0;
  int unsigned         first_total  = 0;
  int unsigned         second_total = 0;
  logic [FIELD_W-1:0]  active_bits  = ACTIVE_BITS_RESET;

  out_word_t   pending_results[$];
  vector_row_t vectors[$];
  int          mismatch_count = 0;
  int          idle_pct       = 6;
  int          stall_pct      = 87;

  logic [FIELD_W-1:0] size_plan [9] = '{11'd1024, 11'd1, 11'd37, 11'd2047, 11'd32,
                                        11'd0, 11'd1025, 11'd0, 11'd1000};

  dual_bitmap_first_difference_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int unsigned eff_span();
    return (active_bits > MAP_BITS) ? MAP_BITS : active_bits;
  endfunction

  function automatic out_word_t next_bitmap_result(in_word_t w);
    out_word_t   r;
    int unsigned lim;
    int unsigned i;
    r   = '0;
    lim = eff_span();
    if (op_t'(w.operation) == OP_SET) begin
      if (w.bit_index >= lim) begin
        r.index_error = 1'b1;
      end else if (w.map_select) begin
        if (second_bits[w.bit_index] != w.bit_value) begin
          r.changed = 1'b1;
          second_bits[w.bit_index] = w.bit_value;
          second_total = w.bit_value ? second_total + 1 : second_total - 1;
        end
      end else begin
        if (first_bits[w.bit_index] != w.bit_value) begin
          r.changed = 1'b1;
          first_bits[w.bit_index] = w.bit_value;
          first_total = w.bit_value ? first_total + 1 : first_total - 1;
        end
      end
    end else begin
      i = 0;
      while (i < lim && first_bits[i] == second_bits[i]) i++;
      if (i < lim) r.diff_position = FIELD_W'(i + 1);
    end
    r.count_first  = FIELD_W'(first_total);
    r.count_second = FIELD_W'(second_total);
    return r;
  endfunction

  function automatic vector_row_t set_row(bit sel, int unsigned idx, bit val);
    vector_row_t r;
    r = '{ROW_WORD, '0, '0, 1'b0, '0};
    r.word.operation  = OP_SET;
    r.word.map_select = sel;
    r.word.bit_index  = INDEX_W'(idx);
    r.word.bit_value  = val;
    return r;
  endfunction

  function automatic vector_row_t find_row();
    vector_row_t r;
    r = '{ROW_WORD, '0, '0, 1'b0, '0};
    r.word.operation  = OP_FIND;
    r.word.map_select = 1'b1;
    r.word.bit_index  = '1;
    r.word.bit_value  = 1'b1;
    return r;
  endfunction

  function automatic vector_row_t size_row(int unsigned v);
    vector_row_t r;
    r = '{ROW_SIZE, FIELD_W'(v), '0, 1'b0, '0};
    return r;
  endfunction

  function automatic vector_row_t with_result(vector_row_t r, bit ch, bit er,
                                             int unsigned cf, int unsigned cs,
                                             int unsigned d);
    r.typed              = 1'b1;
    r.want.changed       = ch;
    r.want.index_error   = er;
    r.want.count_first   = FIELD_W'(cf);
    r.want.count_second  = FIELD_W'(cs);
    r.want.diff_position = FIELD_W'(d);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic send_word(in_word_t w, bit typed, out_word_t want);
    out_word_t model;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = next_bitmap_result(w);
    pending_results.push_back(typed ? want : model);
  endtask

  task automatic write_size(logic [FIELD_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    active_bits = v;
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: %h", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.changed !== want.changed)
          report_mismatch($sformatf("changed %0d, expected %0d",
                                    out_data.changed, want.changed));
        if (out_data.index_error !== want.index_error)
          report_mismatch($sformatf("index_error %0d, expected %0d",
                                    out_data.index_error, want.index_error));
        if (out_data.count_first !== want.count_first)
          report_mismatch($sformatf("count_first %0d, expected %0d",
                                    out_data.count_first, want.count_first));
        if (out_data.count_second !== want.count_second)
          report_mismatch($sformatf("count_second %0d, expected %0d",
                                    out_data.count_second, want.count_second));
        if (out_data.diff_position !== want.diff_position)
          report_mismatch($sformatf("diff_position %0d, expected %0d",
                                    out_data.diff_position, want.diff_position));
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    in_word_t           w;
    logic [FIELD_W-1:0] span;
    int unsigned        lim;
    logic               other;

    vectors.push_back(with_result(find_row(), 0, 0, 0, 0, 0));
    vectors.push_back(with_result(set_row(0, 0, 1), 1, 0, 1, 0, 0));
    vectors.push_back(with_result(find_row(), 0, 0, 1, 0, 1));
    vectors.push_back(with_result(set_row(1, 0, 1), 1, 0, 1, 1, 0));
    vectors.push_back(with_result(find_row(), 0, 0, 1, 1, 0));
    vectors.push_back(with_result(set_row(1, 1023, 1), 1, 0, 1, 2, 0));
    vectors.push_back(with_result(find_row(), 0, 0, 1, 2, 1024));
    vectors.push_back(with_result(set_row(1, 1023, 1), 0, 0, 1, 2, 0));
    vectors.push_back(with_result(set_row(0, 1023, 1), 1, 0, 2, 2, 0));
    vectors.push_back(with_result(find_row(), 0, 0, 2, 2, 0));
    vectors.push_back(with_result(set_row(0, 1023, 0), 1, 0, 1, 2, 0));
    vectors.push_back(with_result(set_row(0, 1023, 0), 0, 0, 1, 2, 0));
    vectors.push_back(set_row(0, 31, 1));
    vectors.push_back(set_row(1, 32, 1));
    vectors.push_back(find_row());
    vectors.push_back(size_row(100));
    vectors.push_back(with_result(set_row(0, 100, 1), 0, 1, 2, 3, 0));
    vectors.push_back(set_row(1, 99, 0));
    vectors.push_back(set_row(0, 99, 1));
    vectors.push_back(find_row());
    vectors.push_back(size_row(0));
    vectors.push_back(set_row(0, 0, 0));
    vectors.push_back(find_row());
    vectors.push_back(size_row(2047));
    vectors.push_back(set_row(1, 1023, 0));
    vectors.push_back(find_row());

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) begin
      if (vectors[i].kind == ROW_SIZE) begin
        write_size(vectors[i].span);
      end else begin
        send_word(vectors[i].word, vectors[i].typed, vectors[i].want);
      end
    end

    for (int seg = 0; seg < 9; seg++) begin
      idle_pct  = (seg < 3) ? 6 : (seg < 6) ? 87 : 0;
      stall_pct = (seg < 3) ? 87 : (seg < 6) ? 6 : 0;
      span = (seg == 7) ? FIELD_W'($urandom_range(2, 1023)) : size_plan[seg];
      write_size(span);
      repeat (211) begin
        lim          = eff_span();
        w.operation  = ($urandom_range(0, 3) == 0) ? OP_FIND : OP_SET;
        w.map_select = 1'($urandom_range(0, 1));
        if (lim != 0 && $urandom_range(0, 4) != 0) begin
          w.bit_index = INDEX_W'($urandom_range(0, lim - 1));
        end else begin
          w.bit_index = INDEX_W'($urandom_range(0, 1023));
        end
        // pull the maps together so that differences stay sparse
        other       = w.map_select ? first_bits[w.bit_index] : second_bits[w.bit_index];
        w.bit_value = ($urandom_range(0, 9) < 6) ? other : 1'($urandom_range(0, 1));
        send_word(w, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
